>>> rtl/kpd_pkg.sv
package kpd_pkg;

  localparam int NUM_ROWS     = 3;
  localparam int KEYS_PER_ROW = 5;
  localparam int NUM_KEYS     = NUM_ROWS * KEYS_PER_ROW;

  localparam int ROW_W  = 2;
  localparam int COL_W  = 5;
  localparam int KEY_W  = 4;
  localparam int CHAR_W = 7;
  localparam int CNT_W  = 4;
  localparam int CIDX_W = 2;

  // configuration register indexes
  localparam logic [CIDX_W-1:0] CFG_PRESS_AT      = 2'd0;
  localparam logic [CIDX_W-1:0] CFG_RELEASE_BELOW = 2'd1;
  localparam logic [CIDX_W-1:0] CFG_COUNT_TOP     = 2'd2;

  localparam logic [CNT_W-1:0] RST_PRESS_AT      = 4'd6;
  localparam logic [CNT_W-1:0] RST_RELEASE_BELOW = 4'd2;
  localparam logic [CNT_W-1:0] RST_COUNT_TOP     = 4'd7;

  localparam logic [KEY_W-1:0] KEY_CLEAR = 4'd12;

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] column_levels;
  } in_t;

  typedef struct packed {
    logic [KEY_W-1:0]  key_index;
    logic [CHAR_W-1:0] character;
    logic              clears;
    logic              last;
  } out_t;

  typedef struct packed {
    logic [CNT_W-1:0] press_at;
    logic [CNT_W-1:0] release_below;
    logic [CNT_W-1:0] count_top;
  } cfg_t;

  // one row worth of new presses, handed from front to back
  typedef struct packed {
    logic [ROW_W-1:0]        row;
    logic [KEYS_PER_ROW-1:0] mask;
  } press_t;

  function automatic logic [CHAR_W-1:0] key_char(input logic [KEY_W-1:0] key);
    logic [CHAR_W-1:0] ch;
    case (key)
      4'd0:    ch = 7'h30;
      4'd1:    ch = 7'h31;
      4'd2:    ch = 7'h32;
      4'd3:    ch = 7'h33;
      4'd4:    ch = 7'h34;
      4'd5:    ch = 7'h35;
      4'd6:    ch = 7'h36;
      4'd7:    ch = 7'h37;
      4'd8:    ch = 7'h38;
      4'd9:    ch = 7'h39;
      4'd10:   ch = 7'h2C;
      4'd11:   ch = 7'h2D;
      4'd13:   ch = 7'h2E;
      4'd14:   ch = 7'h65;
      default: ch = '0;
    endcase
    return ch;
  endfunction

endpackage

>>> rtl/kpd_front.sv
module kpd_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           accept_i,
  input  kpd_pkg::in_t   item_i,
  input  kpd_pkg::cfg_t  cfg_i,
  output logic           push_o,
  output kpd_pkg::press_t press_o
);

  logic [kpd_pkg::CNT_W-1:0] cnt_q [kpd_pkg::NUM_ROWS][kpd_pkg::KEYS_PER_ROW];
  logic [kpd_pkg::CNT_W-1:0] cnt_d [kpd_pkg::KEYS_PER_ROW];
  logic [kpd_pkg::KEYS_PER_ROW-1:0] pressed_q [kpd_pkg::NUM_ROWS];
  logic [kpd_pkg::KEYS_PER_ROW-1:0] pressed_d;
  logic [kpd_pkg::KEYS_PER_ROW-1:0] new_press;
  logic [kpd_pkg::CNT_W-1:0] cur_cnt [kpd_pkg::KEYS_PER_ROW];
  logic [kpd_pkg::KEYS_PER_ROW-1:0] cur_pressed;
  logic row_ok;
  logic lvl;

  assign row_ok = (32'(item_i.row) < kpd_pkg::NUM_ROWS);

  always_comb begin
    cur_pressed = '0;
    for (int c = 0; c < kpd_pkg::KEYS_PER_ROW; c++) begin
      cur_cnt[c] = '0;
    end
    for (int r = 0; r < kpd_pkg::NUM_ROWS; r++) begin
      if (32'(item_i.row) == r) begin
        cur_pressed = pressed_q[r];
        for (int c = 0; c < kpd_pkg::KEYS_PER_ROW; c++) begin
          cur_cnt[c] = cnt_q[r][c];
        end
      end
    end
  end

  // independent saturating counter update per column
  always_comb begin
    pressed_d = cur_pressed;
    new_press = '0;
    lvl       = 1'b0;
    for (int c = 0; c < kpd_pkg::KEYS_PER_ROW; c++) begin
      cnt_d[c] = cur_cnt[c];
      lvl = (c < kpd_pkg::COL_W) ? item_i.column_levels[c] : 1'b0;
      if (lvl) begin
        if (cur_cnt[c] < cfg_i.count_top) begin
          cnt_d[c] = cur_cnt[c] + 1'b1;
          if ((cnt_d[c] >= cfg_i.press_at) && !cur_pressed[c]) begin
            pressed_d[c] = 1'b1;
            new_press[c] = 1'b1;
          end
        end
      end else begin
        if (cur_cnt[c] != '0) begin
          cnt_d[c] = cur_cnt[c] - 1'b1;
          if ((cnt_d[c] < cfg_i.release_below) && cur_pressed[c]) begin
            pressed_d[c] = 1'b0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < kpd_pkg::NUM_ROWS; r++) begin
        pressed_q[r] <= '0;
        for (int c = 0; c < kpd_pkg::KEYS_PER_ROW; c++) begin
          cnt_q[r][c] <= '0;
        end
      end
    end else if (accept_i && row_ok) begin
      for (int r = 0; r < kpd_pkg::NUM_ROWS; r++) begin
        if (32'(item_i.row) == r) begin
          pressed_q[r] <= pressed_d;
          for (int c = 0; c < kpd_pkg::KEYS_PER_ROW; c++) begin
            cnt_q[r][c] <= cnt_d[c];
          end
        end
      end
    end
  end

  assign push_o        = accept_i && row_ok && (new_press != '0);
  assign press_o.row   = item_i.row;
  assign press_o.mask  = new_press;

endmodule

>>> rtl/kpd_fifo.sv
module kpd_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  kpd_pkg::press_t data_i,
  input  logic            pop_i,
  output logic            full_o,
  output logic            valid_o,
  output kpd_pkg::press_t data_o
);

  kpd_pkg::press_t mem_q [2];
  logic       wr_ptr_q;
  logic       rd_ptr_q;
  logic [1:0] count_q;
  logic [1:0] count_d;

  assign full_o  = (count_q == 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 2'd1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

>>> rtl/kpd_back.sv
module kpd_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            head_valid_i,
  input  kpd_pkg::press_t head_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output kpd_pkg::out_t   out_data_o
);

  logic                               work_valid_q;
  logic [kpd_pkg::ROW_W-1:0]          work_row_q;
  logic [kpd_pkg::KEYS_PER_ROW-1:0]   work_mask_q;
  logic [kpd_pkg::KEYS_PER_ROW-1:0]   rem_mask;
  logic [kpd_pkg::KEY_W-1:0]          key;
  logic [kpd_pkg::KEY_W-1:0]          col;
  logic                               advance;
  logic                               load;
  logic                               out_valid_q;
  kpd_pkg::out_t                      out_q;
  kpd_pkg::out_t                      ev;

  // lowest pending column goes first
  always_comb begin
    col = '0;
    for (int c = kpd_pkg::KEYS_PER_ROW - 1; c >= 0; c--) begin
      if (work_mask_q[c]) begin
        col = kpd_pkg::KEY_W'(c);
      end
    end
  end

  assign rem_mask = work_mask_q & (work_mask_q - 1'b1);
  assign key = kpd_pkg::KEY_W'(work_row_q * kpd_pkg::KEYS_PER_ROW) + col;

  always_comb begin
    ev.key_index = key;
    ev.character = kpd_pkg::key_char(key);
    ev.clears    = (key == kpd_pkg::KEY_CLEAR);
    ev.last      = (rem_mask == '0);
  end

  assign advance = work_valid_q && (!out_valid_q || !out_stall_i);
  assign load    = head_valid_i && (!work_valid_q || (advance && ev.last));
  assign pop_o   = load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      work_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (load) begin
        work_valid_q <= 1'b1;
      end else if (advance && ev.last) begin
        work_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      work_row_q  <= head_i.row;
      work_mask_q <= head_i.mask;
    end else if (advance) begin
      work_mask_q <= rem_mask;
    end
    if (advance) begin
      out_q <= ev;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

>>> rtl/keypad_scan_debouncer_top.sv
// keypad scan debouncer: each transfer on the input channel carries one driven row and the
// sampled levels of its five columns. every key keeps a saturating hysteresis counter and a
// pressed flag; a new press yields one result transfer (key index, ascii character, clear
// flag for key 12, last flag on the final press of that row), in column order. a row item is
// taken whenever the two-entry press queue has room, so rows stream in back to back; the
// serializer behind the queue sends one press per cycle while the output is not stalled, at
// most five per row, from the work register into the output register. the user must write
// thresholds through the config port only while idle; the block itself does not enforce it.
module keypad_scan_debouncer_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // row scan input
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  kpd_pkg::in_t                 in_data_i,
  // press event output
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output kpd_pkg::out_t                out_data_o,
  // configuration write port
  input  logic                         cfg_we_i,
  input  logic [kpd_pkg::CIDX_W-1:0]   cfg_index_i,
  input  logic [kpd_pkg::CNT_W-1:0]    cfg_data_i
);

  kpd_pkg::cfg_t   cfg_q;
  kpd_pkg::press_t front_press;
  kpd_pkg::press_t head;
  logic            in_accept;
  logic            push;
  logic            pop;
  logic            q_full;
  logic            head_valid;

  // threshold registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.press_at      <= kpd_pkg::RST_PRESS_AT;
      cfg_q.release_below <= kpd_pkg::RST_RELEASE_BELOW;
      cfg_q.count_top     <= kpd_pkg::RST_COUNT_TOP;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        kpd_pkg::CFG_PRESS_AT:      cfg_q.press_at      <= cfg_data_i;
        kpd_pkg::CFG_RELEASE_BELOW: cfg_q.release_below <= cfg_data_i;
        kpd_pkg::CFG_COUNT_TOP:     cfg_q.count_top     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // rows are only held off when the press queue is full
  assign in_stall_o = q_full;
  assign in_accept  = in_valid_i && !q_full;

  // front: counter update and press detection for the whole row
  kpd_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (in_accept),
    .item_i   (in_data_i),
    .cfg_i    (cfg_q),
    .push_o   (push),
    .press_o  (front_press)
  );

  // short queue of press masks, rows without presses never enter it
  kpd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (front_press),
    .pop_i   (pop),
    .full_o  (q_full),
    .valid_o (head_valid),
    .data_o  (head)
  );

  // back: one press event per cycle into the output register while the output is not stalled
  kpd_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_data_o   (out_data_o)
  );

  // clear flag only ever belongs to key 12
  a_clear_key: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.clears |-> out_data_o.key_index == kpd_pkg::KEY_CLEAR)
    else $error("clear flag on a key other than the clear key");

  // no event for a key that does not exist
  a_key_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> 32'(out_data_o.key_index) < kpd_pkg::NUM_KEYS)
    else $error("press event for a key beyond the keypad");

  // presses of one row leave without gaps until the last one
  a_no_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !out_data_o.last |=> out_valid_o)
    else $error("gap inside the press events of one row");

endmodule

>>> tb/kpd_press_checker.sv
`timescale 1ns / 100ps

module kpd_press_checker
  import kpd_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_stall_i,
  input  in_t               in_data_i,
  input  logic              out_valid_i,
  input  logic              out_stall_i,
  input  out_t              out_data_i,
  input  logic              cfg_we_i,
  input  logic [CIDX_W-1:0] cfg_index_i,
  input  logic [CNT_W-1:0]  cfg_data_i,
  output int                fail_count_o,
  output int                pending_o,
  output int                press_count_o
);

  localparam logic [CHAR_W-1:0] CH_ZERO  = 7'h30;
  localparam logic [CHAR_W-1:0] CH_COMMA = 7'h2C;
  localparam logic [CHAR_W-1:0] CH_MINUS = 7'h2D;
  localparam logic [CHAR_W-1:0] CH_DOT   = 7'h2E;
  localparam logic [CHAR_W-1:0] CH_E     = 7'h65;
  localparam logic [CHAR_W-1:0] CH_NONE  = '0;

  cfg_t             thresholds;
  logic [CNT_W-1:0] key_count [NUM_KEYS];
  logic             key_down  [NUM_KEYS];
  out_t             press_q [$];
  int               fail_cnt;
  int               press_cnt;

  // ascii glyph printed on each key cap, the clear key has none
  function automatic logic [CHAR_W-1:0] glyph_of(input int key);
    if (key < 10) return CH_ZERO + CHAR_W'(key);
    case (key)
      10:      return CH_COMMA;
      11:      return CH_MINUS;
      13:      return CH_DOT;
      14:      return CH_E;
      default: return CH_NONE;
    endcase
  endfunction

  // debounce one scanned row and queue the presses it causes, in column order
  function automatic void scan_row(input in_t item);
    out_t held;
    bit   have;
    int   key;
    have = 1'b0;
    held = '0;
    if (item.row >= NUM_ROWS) return;
    for (int c = 0; c < KEYS_PER_ROW; c++) begin
      key = item.row * KEYS_PER_ROW + c;
      if (item.column_levels[c]) begin
        if (key_count[key] < thresholds.count_top) begin
          key_count[key] = key_count[key] + 1'b1;
          if (key_count[key] >= thresholds.press_at && !key_down[key]) begin
            key_down[key] = 1'b1;
            if (have) press_q.push_back(held);
            held.key_index = KEY_W'(key);
            held.character = glyph_of(key);
            held.clears    = (KEY_W'(key) == KEY_CLEAR);
            held.last      = 1'b0;
            have = 1'b1;
          end
        end
      end else if (key_count[key] != '0) begin
        key_count[key] = key_count[key] - 1'b1;
        if (key_count[key] < thresholds.release_below) key_down[key] = 1'b0;
      end
    end
    if (have) begin
      held.last = 1'b1;
      press_q.push_back(held);
    end
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      fail_cnt++;
    end
  endfunction

  function automatic void check_press(input out_t got);
    out_t want;
    press_cnt++;
    if (press_q.size() == 0) begin
      $display("%0t: press event with none expected: expected nothing, actual key %0d char %02h",
               $time, got.key_index, got.character);
      fail_cnt++;
      return;
    end
    want = press_q.pop_front();
    check_field("key_index", 32'(want.key_index), 32'(got.key_index));
    check_field("character", 32'(want.character), 32'(got.character));
    check_field("clears", 32'(want.clears), 32'(got.clears));
    check_field("last", 32'(want.last), 32'(got.last));
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresholds.press_at      = RST_PRESS_AT;
      thresholds.release_below = RST_RELEASE_BELOW;
      thresholds.count_top     = RST_COUNT_TOP;
      for (int k = 0; k < NUM_KEYS; k++) begin
        key_count[k] = '0;
        key_down[k]  = 1'b0;
      end
      press_q.delete();
      fail_cnt  = 0;
      press_cnt = 0;
    end else begin
      // results are checked before the row taken at the same edge adds to the queue
      if (out_valid_i && !out_stall_i) check_press(out_data_i);
      if (in_valid_i && !in_stall_i) scan_row(in_data_i);
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_PRESS_AT:      thresholds.press_at      = cfg_data_i;
          CFG_RELEASE_BELOW: thresholds.release_below = cfg_data_i;
          CFG_COUNT_TOP:     thresholds.count_top     = cfg_data_i;
          default: ;
        endcase
      end
    end
    fail_count_o  <= fail_cnt;
    pending_o     <= press_q.size();
    press_count_o <= press_cnt;
  end

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import kpd_pkg::*;

  // no transfer for this long means the block hung
  localparam int WATCHDOG_LIMIT = 2000;
  // cycles left after the last expected press before a register write
  localparam int SETTLE_CYCLES  = 12;
  // cycles left after the last expected press before the verdict
  localparam int DRAIN_CYCLES   = 20;
  // long receiver hold-off that fills the press queue
  localparam int HOLD_CYCLES    = 120;
  localparam int PHASE_SCANS    = 47;
  localparam logic [ROW_W-1:0] ROW_UNUSED = ROW_W'(NUM_ROWS);

  logic              clk = 1'b0;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  in_t               in_data;
  logic              out_valid;
  logic              out_stall;
  out_t              out_data;
  logic              cfg_we;
  logic [CIDX_W-1:0] cfg_index;
  logic [CNT_W-1:0]  cfg_data;

  int fail_count;
  int pending;
  int press_count;

  // knobs for the sender and the receiver, set per phase
  int gap_max   = 0;
  int stall_pct = 0;
  int burst_left = 0;
  int scans_sent = 0;
  bit hold_req  = 1'b0;

  always #4 clk = ~clk;

  keypad_scan_debouncer_top i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  kpd_press_checker i_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_i    (in_stall),
    .in_data_i     (in_data),
    .out_valid_i   (out_valid),
    .out_stall_i   (out_stall),
    .out_data_i    (out_data),
    .cfg_we_i      (cfg_we),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data),
    .fail_count_o  (fail_count),
    .pending_o     (pending),
    .press_count_o (press_count)
  );

  // offer one row scan and wait for its transfer; a new burst may start with a gap
  task automatic send_row(input logic [ROW_W-1:0] r, input logic [COL_W-1:0] lv);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 8);
      gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    if (r < NUM_ROWS) scans_sent++;
    in_valid <= 1'b1;
    in_data  <= '{row: r, column_levels: lv};
    do @(posedge clk); while (in_stall);
  endtask

  // stop offering, wait for every expected press, then let the pipe empty
  task automatic drain(input int cycles);
    in_valid <= 1'b0;
    burst_left = 0;
    // wait for an edge so the pending count includes the row taken just now
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (cycles) @(posedge clk);
  endtask

  // write all three thresholds on back-to-back edges, block must be idle
  task automatic set_thresholds(input logic [CNT_W-1:0] p, input logic [CNT_W-1:0] rel,
                                input logic [CNT_W-1:0] top);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_PRESS_AT;
    cfg_data  <= p;
    @(posedge clk);
    cfg_index <= CFG_RELEASE_BELOW;
    cfg_data  <= rel;
    @(posedge clk);
    cfg_index <= CFG_COUNT_TOP;
    cfg_data  <= top;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // receiver: runs of stall and no stall of random length, or one long hold-off on request
  initial begin : receiver
    int  run_left;
    bit  stall_now;
    run_left = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
        out_stall <= 1'b0;
        run_left = 0;
      end else begin
        if (run_left == 0) begin
          stall_now = ($urandom_range(0, 99) < stall_pct);
          run_left  = $urandom_range(1, 5);
          out_stall <= stall_now;
        end
        run_left--;
      end
    end
  end

  // watchdog: counts cycles with no transfer on any port
  initial begin : watchdog
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) quiet = 0;
      else quiet++;
      if (quiet >= WATCHDOG_LIMIT) begin
        $display("%0t: watchdog: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  initial begin : stimulus
    logic [COL_W-1:0] held [NUM_ROWS];
    logic [COL_W-1:0] levels;
    logic [ROW_W-1:0] scan_row;
    int               sent;

    // every input known from time zero, reset asserted first
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= CFG_PRESS_AT;
    cfg_data  <= '0;
    for (int r = 0; r < NUM_ROWS; r++) held[r] = '0;
    scan_row = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part, fast thresholds so each step shows up at once
    set_thresholds(4'd1, 4'd1, 4'd2);
    send_row(2'd0, 5'b11111);     // five presses from one row
    send_row(2'd1, 5'b11111);
    send_row(2'd2, 5'b11111);     // comma, minus, clear key, dot, e
    send_row(ROW_UNUSED, 5'b11111); // row that does not exist is ignored
    send_row(2'd0, 5'b11111);     // counter reaches top, already pressed
    send_row(2'd0, 5'b11111);     // saturated counter stays put
    send_row(2'd0, 5'b00000);     // not yet below release level
    send_row(2'd0, 5'b00000);     // release
    send_row(2'd0, 5'b00000);     // counter at zero stays put
    send_row(2'd0, 5'b10101);     // presses on alternate columns
    send_row(2'd2, 5'b01010);
    send_row(2'd2, 5'b00100);     // clear key alone
    drain(SETTLE_CYCLES);

    // press at zero and release above press: every high after a low presses
    set_thresholds(4'd0, 4'd15, 4'd15);
    send_row(2'd1, 5'b00000);
    send_row(2'd1, 5'b10001);
    send_row(2'd1, 5'b00000);
    send_row(2'd1, 5'b11111);
    drain(SETTLE_CYCLES);

    // counter top of zero: no increment, no press; release level zero never releases
    set_thresholds(4'd15, 4'd0, 4'd0);
    send_row(2'd1, 5'b11111);
    send_row(2'd1, 5'b00000);
    send_row(2'd2, 5'b11111);

    // random phases: each row holds a key pattern that changes now and then,
    // with contact bounce, pure noise scans and stray scans of the unused row
    for (int ph = 0; ph < 7; ph++) begin
      drain(SETTLE_CYCLES);
      case (ph)
        0: begin
          set_thresholds(RST_PRESS_AT, RST_RELEASE_BELOW, RST_COUNT_TOP);
          gap_max = 3;  stall_pct = 30;
        end
        1: begin
          // chattering keys press on every high after a low, receiver holds off for a long stretch
          set_thresholds(4'd1, 4'd1, 4'd1);
          gap_max = 0;  stall_pct = 0;
          hold_req = 1'b1;
        end
        2: begin
          set_thresholds(4'd15, 4'd15, 4'd15);
          gap_max = 6;  stall_pct = 50;
        end
        3: begin
          set_thresholds(4'd3, 4'd1, 4'd4);
          gap_max = 0;  stall_pct = 20;
        end
        4: begin
          set_thresholds(4'd2, 4'd4, 4'd3);
          gap_max = 10; stall_pct = 0;
        end
        5: begin
          set_thresholds(CNT_W'($urandom_range(0, 15)), CNT_W'($urandom_range(0, 15)),
                         CNT_W'($urandom_range(0, 15)));
          gap_max = $urandom_range(0, 8); stall_pct = $urandom_range(0, 60);
        end
        default: begin
          set_thresholds(4'd2, 4'd1, 4'd3);
          gap_max = 2;  stall_pct = 40;
        end
      endcase
      sent = 0;
      while (sent < PHASE_SCANS) begin
        if ($urandom_range(0, 15) == 0) begin
          send_row(ROW_UNUSED, COL_W'($urandom()));
        end else begin
          if ($urandom_range(0, 9) == 0) held[scan_row] = COL_W'($urandom());
          levels = held[scan_row];
          if ($urandom_range(0, 9) == 0) begin
            levels = COL_W'($urandom());
          end else begin
            for (int b = 0; b < COL_W; b++)
              if ($urandom_range(0, 11) == 0) levels[b] = ~levels[b];
          end
          send_row(scan_row, levels);
          scan_row = (scan_row == NUM_ROWS - 1) ? '0 : scan_row + 1'b1;
          sent++;
        end
      end
    end

    drain(DRAIN_CYCLES);
    $display("covered %0d row scans and %0d press events over ten threshold settings,",
             scans_sent, press_count);
    $display("with bursty input, random output stalls and one long output hold-off");
    if (fail_count == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/kpd_pkg.sv
rtl/kpd_front.sv
rtl/kpd_fifo.sv
rtl/kpd_back.sv
rtl/keypad_scan_debouncer_top.sv
tb/kpd_press_checker.sv
tb/tb_top.sv
